[rtl/mephist_pkg.sv]
// Package for the momentum/energy pair histogram.
// Holds command codes, register indexes and the front-to-back queue entry type.
// No dependencies.
package mephist_pkg;

   typedef enum logic [1:0] {
      CMD_ACCUM = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [1:0] REG_G_CUTOFF  = 2'd0;
   localparam logic [1:0] REG_Q_SCALE   = 2'd1;
   localparam logic [1:0] REG_E_SCISSOR = 2'd2;
   localparam logic [1:0] REG_E_SCALE   = 2'd3;

   // One classified operation handed from the front part to the back part.
   // Bins are wide enough for the largest bin counts; the response masks them.
   typedef struct packed {
      logic        hit;     // touch the histogram
      logic        accum;   // increment (else read)
      logic        clear;   // clear after read
      logic        counted;
      logic [11:0] q_bin;
      logic [11:0] e_bin;
   } op_type;

endpackage

[rtl/mephist_front.sv]
// Front part: accepts items and computes the target bin of each.
// A sequential datapath with an iterative square root; uses mephist_pkg.
module mephist_front #(
   parameter int Q_BINS = 1024,
   parameter int E_BINS = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic signed [15:0]   req_dk_x,
   input  logic signed [15:0]   req_dk_y,
   input  logic signed [15:0]   req_dk_z,
   input  logic signed [4:0]    req_g_x,
   input  logic signed [4:0]    req_g_y,
   input  logic signed [4:0]    req_g_z,
   input  logic signed [19:0]   req_e_upper,
   input  logic signed [19:0]   req_e_lower,
   input  logic [9:0]           req_read_q_bin,
   input  logic [8:0]           req_read_e_bin,
   input  logic [3:0]           g_cutoff,
   input  logic [15:0]          q_scale,
   input  logic signed [19:0]   e_scissor,
   input  logic [15:0]          e_scale,
   output logic                 op_valid,
   input  logic                 op_stall,
   output mephist_pkg::op_type  op_data
);

   typedef enum logic [1:0] {S_IDLE, S_ROOT, S_BIN, S_OUT} state_type;

   state_type          state_ff;
   logic [5:0]         step_ff;
   logic [55:0]        rem_ff;     // radicand being consumed two bits a step
   logic [29:0]        root_ff;
   logic [31:0]        acc_ff;
   logic               ok_ff;
   logic [44:0]        eprod_ff;
   logic               eneg_ff;
   mephist_pkg::op_type op_ff;

   // Shifted axis magnitudes: |dk + G*4096| fits 18 bits.
   function automatic logic [35:0] axis_sq(input logic signed [15:0] dk,
                                           input logic signed [4:0] g);
      logic signed [18:0] v;
      logic [17:0] a;
      begin
         v = 19'(dk) + 19'(signed'({g, 12'd0}));
         a = v[18] ? 18'(-v) : 18'(v);
         axis_sq = a * a;
      end
   endfunction

   function automatic logic g_ok(input logic signed [4:0] g, input logic [3:0] c);
      logic [4:0] a;
      begin
         a = g[4] ? 5'(-g) : 5'(g);
         g_ok = a <= {1'b0, c};
      end
   endfunction

   logic [37:0]        sum_sq;
   logic signed [21:0] e_val;
   logic [31:0]        trial;
   logic [31:0]        rem_top;
   logic [47:0]        qprod;
   logic [19:0]        qb_w;
   logic [28:0]        eb_w;

   assign sum_sq = 38'(axis_sq(req_dk_x, req_g_x)) + 38'(axis_sq(req_dk_y, req_g_y))
                 + 38'(axis_sq(req_dk_z, req_g_z));
   assign e_val  = 22'(req_e_upper) - 22'(e_scissor) - 22'(req_e_lower);
   assign trial  = {root_ff, 2'b01};
   assign rem_top = {acc_ff[29:0], rem_ff[55:54]};
   assign qprod  = {18'd0, root_ff} * {32'd0, q_scale};
   assign qb_w   = qprod[47:28];
   assign eb_w   = eprod_ff[44:16];

   assign req_stall = state_ff != S_IDLE;
   assign op_valid  = state_ff == S_OUT;
   assign op_data   = op_ff;

   // Sequencer: classify, root 28 steps, bin, hand off.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               // The radicand is the sum of squares times 2^16.
               rem_ff  <= {2'b00, sum_sq, 16'd0};
               root_ff <= '0;
               acc_ff  <= '0;
               step_ff <= '0;
               eneg_ff <= e_val[21];
               eprod_ff <= 45'(e_val[20:0]) * 45'(e_scale);
               ok_ff   <= g_ok(req_g_x, g_cutoff) && g_ok(req_g_y, g_cutoff)
                          && g_ok(req_g_z, g_cutoff);
               unique case (mephist_pkg::cmd_type'(req_cmd)) inside
                  mephist_pkg::CMD_ACCUM: begin
                     op_ff    <= '0;
                     state_ff <= S_ROOT;
                  end
                  mephist_pkg::CMD_READ, mephist_pkg::CMD_CLEAR: begin
                     op_ff <= '{hit: 32'(req_read_q_bin) < Q_BINS
                                     && 32'(req_read_e_bin) < E_BINS,
                                accum: 1'b0,
                                clear: req_cmd == mephist_pkg::CMD_CLEAR,
                                counted: 1'b0,
                                q_bin: 12'(req_read_q_bin),
                                e_bin: 12'(req_read_e_bin)};
                     state_ff <= S_OUT;
                  end
                  default: begin
                     op_ff    <= '0;
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_ROOT: begin
               // Restoring square root, one result bit per cycle.
               rem_ff <= {rem_ff[53:0], 2'b00};
               if (rem_top >= trial) begin
                  acc_ff  <= rem_top - trial;
                  root_ff <= {root_ff[28:0], 1'b1};
               end else begin
                  acc_ff  <= rem_top;
                  root_ff <= {root_ff[28:0], 1'b0};
               end
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'd27) state_ff <= S_BIN;
            end
            S_BIN: begin
               if (ok_ff && !eneg_ff && 32'(qb_w) < Q_BINS && 32'(eb_w) < E_BINS) begin
                  op_ff.hit     <= 1'b1;
                  op_ff.accum   <= 1'b1;
                  op_ff.counted <= 1'b1;
                  op_ff.q_bin   <= qb_w[11:0];
                  op_ff.e_bin   <= eb_w[11:0];
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (!op_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/mephist_queue.sv]
// Two-entry queue between the front and back parts.
// Uses mephist_pkg::op_type.
module mephist_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  mephist_pkg::op_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output mephist_pkg::op_type out_data
);

   mephist_pkg::op_type mem_ff [2];
   logic                wr_ff, rd_ff;
   logic [1:0]          cnt_ff;
   logic                push, pop;

   assign in_stall  = cnt_ff == 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
   end

endmodule

[rtl/mephist_back.sv]
// Back part: histogram memory, clearing pass and read-modify-write.
// Uses mephist_pkg::op_type.
module mephist_back #(
   parameter int Q_BINS = 1024,
   parameter int E_BINS = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   output logic                op_stall,
   input  mephist_pkg::op_type op_data,
   output logic                busy_clear,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_counted,
   output logic [9:0]          rsp_q_bin,
   output logic [8:0]          rsp_e_bin,
   output logic [31:0]         rsp_bin_count
);

   localparam int QW    = $clog2(Q_BINS);
   localparam int EW    = $clog2(E_BINS);
   localparam int AW    = QW + EW;
   localparam int DEPTH = Q_BINS * E_BINS;

   typedef enum logic [1:0] {S_CLR, S_IDLE, S_RD, S_WR} state_type;

   state_type           state_ff;
   logic [AW-1:0]       addr_ff;
   logic [31:0]         mem [DEPTH];
   logic [31:0]         rdata_ff;
   mephist_pkg::op_type op_ff;
   logic                rsp_valid_ff;
   logic                counted_ff;
   logic [9:0]          qb_ff;
   logic [8:0]          eb_ff;
   logic [31:0]         cnt_ff;
   logic [31:0]         newv;
   logic                we;
   logic [31:0]         wdata;
   logic [AW-1:0]       op_addr;
   logic                rsp_load;

   assign op_addr = AW'(32'(op_data.q_bin) * E_BINS + 32'(op_data.e_bin));
   assign newv = (rdata_ff == 32'hFFFF_FFFF) ? rdata_ff : rdata_ff + 32'd1;
   assign op_stall = state_ff != S_IDLE || (rsp_valid_ff && rsp_stall);
   assign busy_clear = state_ff == S_CLR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_counted = counted_ff;
   assign rsp_q_bin = qb_ff;
   assign rsp_e_bin = eb_ff;
   assign rsp_bin_count = cnt_ff;

   // A response word is loaded at the end of a memory op or for an op that misses.
   assign rsp_load = (state_ff == S_WR)
                     || (state_ff == S_IDLE && op_valid && !op_stall && !op_data.hit);

   // Write port: clearing pass, clear-after-read, increment.
   always_comb begin
      we = 1'b0;
      wdata = '0;
      if (state_ff == S_CLR) we = 1'b1;
      else if (state_ff == S_WR && (op_ff.accum || op_ff.clear)) begin
         we = 1'b1;
         wdata = op_ff.accum ? newv : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[addr_ff] <= wdata;
      rdata_ff <= mem[addr_ff];
   end

   // Sequencer: clear sweep after reset, then a read state and a write state for each op that hits.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLR: begin
               addr_ff <= addr_ff + 1'b1;
               if (32'(addr_ff) == DEPTH - 1) state_ff <= S_IDLE;
            end
            S_IDLE: if (op_valid && !op_stall) begin
               op_ff <= op_data;
               if (op_data.hit) begin
                  addr_ff <= op_addr;
                  state_ff <= S_RD;
               end else begin
                  counted_ff <= 1'b0;
                  qb_ff <= op_data.q_bin[9:0];
                  eb_ff <= op_data.e_bin[8:0];
                  cnt_ff <= '0;
               end
            end
            S_RD: state_ff <= S_WR;
            S_WR: begin
               counted_ff <= op_ff.counted;
               qb_ff <= op_ff.q_bin[9:0];
               eb_ff <= op_ff.e_bin[8:0];
               cnt_ff <= op_ff.accum ? newv : rdata_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/momentum_energy_pair_histogram.sv]
// Top level of the momentum/energy pair histogram.
// Instantiates mephist_front, mephist_queue and mephist_back; uses mephist_pkg.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     cmd, dk, g, energies, read bins
//   rsp      out        rsp_valid/stall     counted, q_bin, e_bin, bin_count
//   csr      in         csr_write           csr_index, csr_data (20 bits)
//
// An accumulate item runs through the bit-serial square root in the front,
// which takes no new item until it has handed the last one off; reads skip
// the root. The back does a memory read-modify-write for an op that touches
// the histogram and skips the memory for an op that misses. After reset a
// clearing pass over all Q_BINS*E_BINS bins runs before items are accepted.
// Either side may stall; the queue decouples front and back.
module momentum_energy_pair_histogram #(
   parameter int Q_BINS = 1024,
   parameter int E_BINS = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic signed [15:0]  req_dk_x,
   input  logic signed [15:0]  req_dk_y,
   input  logic signed [15:0]  req_dk_z,
   input  logic signed [4:0]   req_g_x,
   input  logic signed [4:0]   req_g_y,
   input  logic signed [4:0]   req_g_z,
   input  logic signed [19:0]  req_e_upper,
   input  logic signed [19:0]  req_e_lower,
   input  logic [9:0]          req_read_q_bin,
   input  logic [8:0]          req_read_e_bin,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [19:0]         csr_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_counted,
   output logic [9:0]          rsp_q_bin,
   output logic [8:0]          rsp_e_bin,
   output logic [31:0]         rsp_bin_count
);

   logic [3:0]          g_cutoff_ff;
   logic [15:0]         q_scale_ff;
   logic signed [19:0]  e_scissor_ff;
   logic [15:0]         e_scale_ff;
   logic                front_stall, busy_clear;
   logic                f_valid, f_stall, b_valid, b_stall;
   mephist_pkg::op_type f_data, b_data;
   logic                req_valid_gated;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         g_cutoff_ff  <= 4'd2;
         q_scale_ff   <= 16'd9567;
         e_scissor_ff <= '0;
         e_scale_ff   <= 16'd655;
      end else if (csr_write) begin
         unique case (csr_index)
            mephist_pkg::REG_G_CUTOFF:  g_cutoff_ff  <= csr_data[3:0];
            mephist_pkg::REG_Q_SCALE:   q_scale_ff   <= csr_data[15:0];
            mephist_pkg::REG_E_SCISSOR: e_scissor_ff <= csr_data;
            mephist_pkg::REG_E_SCALE:   e_scale_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Hold off input during the clearing pass.
   assign req_valid_gated = req_valid && !busy_clear;
   assign req_stall = front_stall || busy_clear;

   mephist_front #(.Q_BINS(Q_BINS), .E_BINS(E_BINS)) u_front (
      .clock, .reset,
      .req_valid(req_valid_gated), .req_stall(front_stall),
      .req_cmd, .req_dk_x, .req_dk_y, .req_dk_z, .req_g_x, .req_g_y, .req_g_z,
      .req_e_upper, .req_e_lower, .req_read_q_bin, .req_read_e_bin,
      .g_cutoff(g_cutoff_ff), .q_scale(q_scale_ff),
      .e_scissor(e_scissor_ff), .e_scale(e_scale_ff),
      .op_valid(f_valid), .op_stall(f_stall), .op_data(f_data)
   );

   mephist_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
   );

   mephist_back #(.Q_BINS(Q_BINS), .E_BINS(E_BINS)) u_back (
      .clock, .reset,
      .op_valid(b_valid), .op_stall(b_stall), .op_data(b_data),
      .busy_clear,
      .rsp_valid, .rsp_stall, .rsp_counted, .rsp_q_bin, .rsp_e_bin, .rsp_bin_count
   );

endmodule

[tb/momentum_energy_pair_histogram_test.sv]
// Self-checking testbench for momentum_energy_pair_histogram.
// Drives accumulate, read, clear and no-op words, predicts every response from a local histogram copy.
// Depends on mephist_pkg and the block's RTL.
module momentum_energy_pair_histogram_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      mephist_pkg::cmd_type cmd;
      logic signed [15:0] dk_x, dk_y, dk_z;
      logic signed [4:0]  g_x, g_y, g_z;
      logic signed [19:0] e_upper, e_lower;
      logic [9:0]         read_q_bin;
      logic [8:0]         read_e_bin;
   } pair_word_type;

   typedef struct {
      logic        counted;
      logic [9:0]  q_bin;
      logic [8:0]  e_bin;
      logic [31:0] bin_count;
   } bin_report_type;

   localparam int QB = 1024;
   localparam int EB = 512;
   localparam int STALL_LIMIT = 2000000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   logic [1:0] req_cmd = 0;
   logic signed [15:0] req_dk_x = 0, req_dk_y = 0, req_dk_z = 0;
   logic signed [4:0] req_g_x = 0, req_g_y = 0, req_g_z = 0;
   logic signed [19:0] req_e_upper = 0, req_e_lower = 0;
   logic [9:0] req_read_q_bin = 0;
   logic [8:0] req_read_e_bin = 0;
   logic csr_write = 0;
   logic [1:0] csr_index = 0;
   logic [19:0] csr_data = 0;
   logic rsp_valid, rsp_stall = 0, rsp_counted;
   logic [9:0] rsp_q_bin;
   logic [8:0] rsp_e_bin;
   logic [31:0] rsp_bin_count;

   // Local copy of the histogram and the registers.
   logic [31:0] hist_copy [int];
   logic [3:0]  cut_reg;
   logic [15:0] qscale_reg, escale_reg;
   logic signed [19:0] scissor_reg;

   pair_word_type  pending_words[$];
   bin_report_type expected_reports[$];
   int errors = 0;
   int sender_idle_pct = 0, receiver_idle_pct = 0;
   int quiet_cycles = 0;

   momentum_energy_pair_histogram DUT (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic g_within(logic signed [4:0] g);
      int a;
      a = (g < 0) ? -int'(g) : int'(g);
      return a <= int'(cut_reg);
   endfunction

   function automatic longint axis_square(logic signed [15:0] dk, logic signed [4:0] g);
      longint v;
      v = longint'(dk) + longint'(g) * 4096;
      return v * v;
   endfunction

   // Applies one word to the local histogram and returns the response it causes.
   function automatic bin_report_type histogram_update(pair_word_type w);
      bin_report_type r;
      logic [63:0] s, m, qb, eb;
      longint e;
      int idx;
      r = '{1'b0, 10'd0, 9'd0, 32'd0};
      if (w.cmd == mephist_pkg::CMD_ACCUM) begin
         if (!g_within(w.g_x) || !g_within(w.g_y) || !g_within(w.g_z)) return r;
         s = axis_square(w.dk_x, w.g_x) + axis_square(w.dk_y, w.g_y)
             + axis_square(w.dk_z, w.g_z);
         m = int_sqrt(s << 16);
         qb = (m * qscale_reg) >> 28;
         e = longint'(w.e_upper) - longint'(scissor_reg) - longint'(w.e_lower);
         if (e < 0) return r;
         eb = (64'(e) * escale_reg) >> 16;
         if (qb >= QB || eb >= EB) return r;
         idx = int'(qb) * EB + int'(eb);
         if (!hist_copy.exists(idx)) hist_copy[idx] = 32'd0;
         if (hist_copy[idx] != 32'hFFFF_FFFF) hist_copy[idx] = hist_copy[idx] + 32'd1;
         r = '{1'b1, qb[9:0], eb[8:0], hist_copy[idx]};
      end else if (w.cmd == mephist_pkg::CMD_READ || w.cmd == mephist_pkg::CMD_CLEAR) begin
         idx = int'(w.read_q_bin) * EB + int'(w.read_e_bin);
         r.q_bin = w.read_q_bin;
         r.e_bin = w.read_e_bin;
         r.bin_count = hist_copy.exists(idx) ? hist_copy[idx] : 32'd0;
         if (w.cmd == mephist_pkg::CMD_CLEAR) hist_copy[idx] = 32'd0;
      end
      return r;
   endfunction

   // Appends one word to the pending queue.
   function automatic void queue_word(pair_word_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   // Sender: predict on acceptance, then present the next word or idle.
   always @(posedge clock) begin
      pair_word_type w;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_reports.insert(expected_reports.size(),
               histogram_update(pair_word_type'{mephist_pkg::cmd_type'(req_cmd), req_dk_x,
               req_dk_y, req_dk_z, req_g_x, req_g_y, req_g_z, req_e_upper, req_e_lower,
               req_read_q_bin, req_read_e_bin}));
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               w = pending_words.pop_front();
               req_valid <= 1'b1;
               req_cmd <= w.cmd;
               req_dk_x <= w.dk_x;
               req_dk_y <= w.dk_y;
               req_dk_z <= w.dk_z;
               req_g_x <= w.g_x;
               req_g_y <= w.g_y;
               req_g_z <= w.g_z;
               req_e_upper <= w.e_upper;
               req_e_lower <= w.e_lower;
               req_read_q_bin <= w.read_q_bin;
               req_read_e_bin <= w.read_e_bin;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Receiver: random stall and field-by-field comparison.
   always @(posedge clock) begin
      bin_report_type want;
      rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("unexpected response word", 32'd1, 32'd0);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_counted !== want.counted)
               report_mismatch("counted", 32'(rsp_counted), 32'(want.counted));
            if (rsp_q_bin !== want.q_bin)
               report_mismatch("q_bin", 32'(rsp_q_bin), 32'(want.q_bin));
            if (rsp_e_bin !== want.e_bin)
               report_mismatch("e_bin", 32'(rsp_e_bin), 32'(want.e_bin));
            if (rsp_bin_count !== want.bin_count)
               report_mismatch("bin_count", rsp_bin_count, want.bin_count);
         end
      end
   end

   // Watchdog on cycles without any handshake; covers the clearing pass too.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] index, logic [19:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      case (index)
         mephist_pkg::REG_G_CUTOFF:  cut_reg = value[3:0];
         mephist_pkg::REG_Q_SCALE:   qscale_reg = value[15:0];
         mephist_pkg::REG_E_SCISSOR: scissor_reg = value;
         default:                    escale_reg = value[15:0];
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_registers(logic [3:0] c, logic [15:0] qs, logic [19:0] sc,
                                 logic [15:0] es);
      write_reg(mephist_pkg::REG_G_CUTOFF, 20'(c));
      write_reg(mephist_pkg::REG_Q_SCALE, 20'(qs));
      write_reg(mephist_pkg::REG_E_SCISSOR, sc);
      write_reg(mephist_pkg::REG_E_SCALE, 20'(es));
   endtask

   // Waits until every predicted response has come back, then lets the front drain.
   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_reports.size() != 0 || req_valid)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic pair_word_type accum_word(int dx, int dy, int dz, int gx, int gy,
                                                int gz, int up, int lo);
      pair_word_type w;
      w.cmd = mephist_pkg::CMD_ACCUM;
      w.dk_x = 16'(dx);
      w.dk_y = 16'(dy);
      w.dk_z = 16'(dz);
      w.g_x = 5'(gx);
      w.g_y = 5'(gy);
      w.g_z = 5'(gz);
      w.e_upper = 20'(up);
      w.e_lower = 20'(lo);
      w.read_q_bin = 10'd0;
      w.read_e_bin = 9'd0;
      return w;
   endfunction

   function automatic pair_word_type read_word(mephist_pkg::cmd_type c, int qb, int eb);
      pair_word_type w;
      w = accum_word(0, 0, 0, 0, 0, 0, 0, 0);
      w.cmd = c;
      w.read_q_bin = 10'(qb);
      w.read_e_bin = 9'(eb);
      return w;
   endfunction

   // Mostly well-formed pairs that land in bins, some noise, reads, clears and no-op words.
   function automatic pair_word_type random_word();
      pair_word_type w;
      int sel, lo, lim;
      sel = $urandom_range(0, 99);
      lim = int'(cut_reg);
      if (sel < 70) begin
         w.cmd = mephist_pkg::CMD_ACCUM;
         if ($urandom_range(0, 2) == 0) begin
            w.dk_x = 16'($urandom); w.dk_y = 16'($urandom); w.dk_z = 16'($urandom);
         end else begin
            w.dk_x = 16'(int'($urandom_range(0, 600)) - 300);
            w.dk_y = 16'(int'($urandom_range(0, 600)) - 300);
            w.dk_z = 16'(int'($urandom_range(0, 600)) - 300);
         end
         if ($urandom_range(0, 5) == 0) begin
            w.g_x = 5'($urandom); w.g_y = 5'($urandom); w.g_z = 5'($urandom);
         end else begin
            w.g_x = 5'(int'($urandom_range(0, 2 * lim)) - lim);
            w.g_y = 5'(int'($urandom_range(0, 2 * lim)) - lim);
            w.g_z = 5'(int'($urandom_range(0, 2 * lim)) - lim);
            if ($urandom_range(0, 1)) begin
               w.g_x = 5'sd0; w.g_y = 5'sd0; w.g_z = 5'sd0;
            end
         end
         if ($urandom_range(0, 5) == 0) begin
            w.e_upper = 20'($urandom); w.e_lower = 20'($urandom);
         end else begin
            lo = int'($urandom_range(0, 200000)) - 100000;
            w.e_lower = 20'(lo);
            w.e_upper = 20'(lo + int'(scissor_reg) + int'($urandom_range(0, 9000)) - 500);
         end
         w.read_q_bin = 10'($urandom);
         w.read_e_bin = 9'($urandom);
      end else begin
         w = accum_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
         w.cmd = (sel < 83) ? mephist_pkg::CMD_READ :
                 (sel < 95) ? mephist_pkg::CMD_CLEAR : mephist_pkg::CMD_NONE;
         if ($urandom_range(0, 4) != 0) begin
            w.read_q_bin = 10'($urandom_range(0, 6));
            w.read_e_bin = 9'($urandom_range(0, 90));
         end else begin
            w.read_q_bin = 10'($urandom);
            w.read_e_bin = 9'($urandom);
         end
      end
      return w;
   endfunction

   task automatic random_phase(int count, int send_idle, int recv_idle);
      sender_idle_pct = send_idle;
      receiver_idle_pct = recv_idle;
      repeat (count) queue_word(random_word());
      wait_drained();
   endtask

   initial begin
      cut_reg = 4'd2;
      qscale_reg = 16'd9567;
      scissor_reg = 20'sd0;
      escale_reg = 16'd655;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset register values.
      queue_word(accum_word(100, 0, 0, 0, 0, 0, 1000, 0));
      queue_word(accum_word(100, 0, 0, 0, 0, 0, 1000, 0));
      queue_word(read_word(mephist_pkg::CMD_READ, 0, 10));
      queue_word(read_word(mephist_pkg::CMD_CLEAR, 0, 10));
      queue_word(read_word(mephist_pkg::CMD_READ, 0, 10));
      queue_word(accum_word(32767, 32767, 32767, 2, 2, 2, 524287, 524287));
      queue_word(accum_word(-32768, -32768, -32768, -2, -2, -2, 0, 0));
      queue_word(accum_word(0, 0, 0, 3, 0, 0, 100, 0));
      queue_word(accum_word(0, 0, 0, 0, -16, 0, 100, 0));
      queue_word(accum_word(0, 0, 0, 0, 0, 15, 100, 0));
      queue_word(accum_word(0, 0, 0, 0, 0, 0, 0, 1));
      queue_word(accum_word(0, 0, 0, 0, 0, 0, 524287, -524288));
      queue_word(accum_word(0, 0, 0, 0, 0, 0, 51000, 0));
      queue_word(accum_word(0, 0, 0, 0, 0, 0, 0, 0));
      queue_word(read_word(mephist_pkg::CMD_READ, 1023, 511));
      queue_word(read_word(mephist_pkg::CMD_CLEAR, 1023, 511));
      queue_word(read_word(mephist_pkg::CMD_NONE, 5, 5));
      wait_drained();

      load_registers(4'd15, 16'd65535, 20'h80000, 16'd65535);
      queue_word(accum_word(-32768, 32767, -32768, -16, 15, 15, 0, 0));
      queue_word(accum_word(4, 4, 4, 0, 0, 0, -524288, 0));
      random_phase(400, 19, 80);

      load_registers(4'd0, 16'd0, 20'h7FFFF, 16'd0);
      queue_word(accum_word(0, 0, 0, 0, 0, 0, 524287, -1));
      random_phase(400, 80, 19);

      load_registers(4'($urandom_range(1, 4)), 16'($urandom_range(2000, 20000)),
                     20'(int'($urandom_range(0, 4000)) - 2000),
                     16'($urandom_range(200, 3000)));
      random_phase(400, 0, 0);

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

[filelist.f]
rtl/mephist_pkg.sv
rtl/mephist_front.sv
rtl/mephist_queue.sv
rtl/mephist_back.sv
rtl/momentum_energy_pair_histogram.sv
tb/momentum_energy_pair_histogram_test.sv
